// ===== hdl/lfp_pkg.sv =====
// Package: constants, status codes and register indexes of the lidar frame parser.
`default_nettype none
package lfp_pkg;

	localparam int unsigned SUM_LEN = 8;
	localparam int unsigned POS_W   = 4;

	localparam logic [7:0]       HDR_BYTE     = 8'h59;
	localparam logic [15:0]      BAD_STRENGTH = 16'hFFFF;
	localparam logic [POS_W-1:0] LAST_POS     = POS_W'(SUM_LEN);

	localparam logic [15:0] MIN_STRENGTH_RST = 16'd100;
	localparam logic [15:0] MIN_DIST_RST     = 16'd10;
	localparam logic [15:0] MAX_DIST_RST     = 16'd1200;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_CHECKSUM = 2'd1,
		ST_STRENGTH = 2'd2,
		ST_DISTANCE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CFG_MIN_STRENGTH = 2'd0,
		CFG_MIN_DIST     = 2'd1,
		CFG_MAX_DIST     = 2'd2
	} cfg_idx_t;

endpackage
`default_nettype wire

// ===== hdl/lfp_if.sv =====
// Interfaces: byte input, result output and register write channels.
`default_nettype none
interface lfp_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  rx_byte;
	logic [31:0] now_ms;
	modport source (output valid, output rx_byte, output now_ms, input ready);
	modport sink   (input valid, input rx_byte, input now_ms, output ready);
endinterface

interface lfp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  frame_status;
	logic [15:0] distance_cm;
	logic [15:0] signal_strength;
	logic [31:0] stamp_ms;
	modport source (output valid, output frame_status, output distance_cm,
		output signal_strength, output stamp_ms, input ready);
	modport sink   (input valid, input frame_status, input distance_cm,
		input signal_strength, input stamp_ms, output ready);
endinterface

interface lfp_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/lfp_cell.sv =====
// Byte cell: one stage of the frame shift line with its share of the checksum.
`default_nettype none
module lfp_cell (
	input  wire logic       clk,
	input  wire logic       advance,
	input  wire logic [7:0] data_in,
	input  wire logic [7:0] sum_in,
	output logic [7:0]      data_out,
	output logic [7:0]      sum_out
);
	logic [7:0] data_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			data_q <= data_in;
		end
	end

	assign data_out = data_q;
	// modular sum, wraps at 8 bits
	assign sum_out  = sum_in + data_q;
endmodule
`default_nettype wire

// ===== hdl/lidar_frame_parser.sv =====
// Top level: header hunt, 8-cell byte line with checksum, screening and result register.
//
//  channel  dir  handshake       payload
//  rx       in   valid/ready     rx_byte[7:0], now_ms[31:0]
//  res      out  valid/ready     frame_status[1:0], distance_cm, signal_strength, stamp_ms
//  cfg      in   valid/ready     index[1:0], data[15:0]
//
// One byte is taken every cycle unless rx stalls; a frame's result appears in the cycle after its
// checksum byte is taken, from the single result register.
// The byte line shifts on every taken byte; the cell chain forms the checksum.
// Reset clears the frame position and the result valid flag and loads the default thresholds.
// rx stalls only while a result is held and res.ready is low; cfg never stalls.
`default_nettype none
module lidar_frame_parser (
	input  wire logic clk,
	input  wire logic arst_n,
	lfp_in_if.sink    rx,
	lfp_out_if.source res,
	lfp_cfg_if.sink   cfg
);
	import lfp_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [15:0]      min_strength_q;
	logic [15:0]      min_dist_q;
	logic [15:0]      max_dist_q;
	logic             res_valid_q;
	status_t          status_q;
	logic [15:0]      dist_q;
	logic [15:0]      strength_q;
	logic [31:0]      stamp_q;

	logic             in_acc;
	logic             frame_done;
	logic [7:0]       cell_data [SUM_LEN];
	logic [7:0]       cell_sum  [SUM_LEN];
	logic [15:0]      frame_dist;
	logic [15:0]      strength;
	status_t          status;

	assign rx.ready   = !res_valid_q || res.ready;
	assign in_acc     = rx.valid && rx.ready;
	assign frame_done = in_acc && (pos_q == LAST_POS);
	assign cfg.ready  = 1'b1;

	// cell 0 takes the newest word; frame byte k sits in cell SUM_LEN-1-k
	for (genvar k = 0; k < SUM_LEN; k++) begin : g_cell
		if (k == 0) begin : g_head
			lfp_cell u_cell (
				.clk      (clk),
				.advance  (in_acc),
				.data_in  (rx.rx_byte),
				.sum_in   (8'd0),
				.data_out (cell_data[k]),
				.sum_out  (cell_sum[k])
			);
		end else begin : g_body
			lfp_cell u_cell (
				.clk      (clk),
				.advance  (in_acc),
				.data_in  (cell_data[k-1]),
				.sum_in   (cell_sum[k-1]),
				.data_out (cell_data[k]),
				.sum_out  (cell_sum[k])
			);
		end
	end

	assign frame_dist = {cell_data[SUM_LEN-4], cell_data[SUM_LEN-3]};
	assign strength   = {cell_data[SUM_LEN-6], cell_data[SUM_LEN-5]};

	always_comb begin
		if (cell_sum[SUM_LEN-1] != rx.rx_byte) begin
			status = ST_CHECKSUM;
		end else if (strength < min_strength_q || strength == BAD_STRENGTH) begin
			status = ST_STRENGTH;
		end else if (frame_dist < min_dist_q || frame_dist > max_dist_q) begin
			status = ST_DISTANCE;
		end else begin
			status = ST_OK;
		end
	end

	// frame position: hunt, confirm second header word, then count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (in_acc) begin
			if (pos_q == POS_W'(0)) begin
				pos_q <= (rx.rx_byte == HDR_BYTE) ? POS_W'(1) : POS_W'(0);
			end else if (pos_q == POS_W'(1)) begin
				pos_q <= (rx.rx_byte == HDR_BYTE) ? POS_W'(2) : POS_W'(0);
			end else if (pos_q < LAST_POS) begin
				pos_q <= pos_q + POS_W'(1);
			end else begin
				pos_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_strength_q <= MIN_STRENGTH_RST;
			min_dist_q     <= MIN_DIST_RST;
			max_dist_q     <= MAX_DIST_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_MIN_STRENGTH: min_strength_q <= cfg.data;
				CFG_MIN_DIST:     min_dist_q     <= cfg.data;
				CFG_MAX_DIST:     max_dist_q     <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (frame_done) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_done) begin
			status_q   <= status;
			dist_q     <= frame_dist;
			strength_q <= strength;
			stamp_q    <= rx.now_ms;
		end
	end

	assign res.valid           = res_valid_q;
	assign res.frame_status    = status_q;
	assign res.distance_cm     = dist_q;
	assign res.signal_strength = strength_q;
	assign res.stamp_ms        = stamp_q;
endmodule
`default_nettype wire

// ===== hdl/lfp_checker.sv =====
// Checker: port-level properties of the lidar frame parser, bound to the top level.
`default_nettype none
module lfp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  out_status,
	input wire logic [15:0] out_strength
);
	import lfp_pkg::*;

	// hold a result until it is taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a new result needs a word taken in the cycle before
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result without a taken word");

	// input stalls only behind a held, untaken result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a pending result");

	// a frame that passed the strength screen never carries the invalid strength mark
	a_screen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_status == ST_OK || out_status == ST_DISTANCE)
		|-> out_strength != BAD_STRENGTH)
		else $error("invalid strength passed screening");
endmodule

bind lidar_frame_parser lfp_checker u_lfp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (rx.valid),
	.in_ready     (rx.ready),
	.out_valid    (res.valid),
	.out_ready    (res.ready),
	.out_status   (res.frame_status),
	.out_strength (res.signal_strength)
);
`default_nettype wire
